[hdl/mfw_pkg.sv]
// Shared constants and types for the streaming median filter.
`default_nettype none

package mfw_pkg;

    localparam int KSIZE     = 3;
    localparam int MAX_WIDTH = 1024;

    localparam int PIX_W   = 8;
    localparam int IMG_W   = 11;
    localparam int LINES   = KSIZE - 1;
    localparam int WIN_N   = KSIZE * KSIZE;
    localparam int MED_IDX = WIN_N / 2;
    localparam int LINE_W  = LINES * PIX_W;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(KSIZE);
    localparam int CMP_W   = (IMG_W > COL_W) ? IMG_W : COL_W;

    localparam int WIDTH_RESET = 640;

    typedef logic [PIX_W-1:0]            pix_t;
    typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;

    typedef struct packed {
        logic full;
        logic last;
    } tag_t;

endpackage

`default_nettype wire

[hdl/mfw_median.sv]
// Pipelined odd-even transposition sort that picks the middle of the window.
`default_nettype none

module mfw_median
    import mfw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_valid,
    input  wire tag_t in_tag,
    input  wire win_t in_win,
    output logic      out_valid,
    output tag_t      out_tag,
    output pix_t      out_med
);

    win_t             stage_reg [WIN_N];
    tag_t             tag_reg   [WIN_N];
    logic [WIN_N-1:0] vld_reg;

    // One compare-exchange layer per register stage; WIN_N layers sort fully.
    for (genvar k = 0; k < WIN_N; k++) begin : g_layer
        localparam int PAR = k % 2;
        win_t cur;
        win_t nxt;

        if (k == 0) begin : g_first
            assign cur = in_win;
        end else begin : g_rest
            assign cur = stage_reg[k-1];
        end

        always_comb
        begin
            nxt = cur;
            for (int i = PAR; i + 1 < WIN_N; i += 2)
            begin
                if (cur[i] > cur[i+1])
                begin
                    nxt[i]   = cur[i+1];
                    nxt[i+1] = cur[i];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[k] <= nxt;
                tag_reg[k]   <= (k == 0) ? in_tag : tag_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[WIN_N-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[WIN_N-1];
    assign out_tag   = tag_reg[WIN_N-1];
    assign out_med   = stage_reg[WIN_N-1][MED_IDX];

endmodule

`default_nettype wire

[hdl/median_filter_window_top.sv]
// Top level of the streaming KSIZE x KSIZE median filter.
//
// Pixels enter in raster order on the input channel (in_valid / in_stall),
// one word per pixel, with frame_start set on the first pixel of an image.
// Each accepted word yields exactly one result word on the output channel
// (out_valid / out_stall): the median of the window whose lower-right corner
// is that pixel, the window_full flag and the row_end flag. Where the window
// is not yet fully inside the image, median_value is 0 and window_full is 0.
// The image width is set through the configuration channel (cfg_valid /
// cfg_ready / image_width); the user must write it only while the block is
// idle, which the block itself does not enforce, and cfg_ready is always high.
//
// Throughput is one pixel per clock while no result is held back. Each
// accepted pixel passes through the line store read, the window shift and
// then WIN_N compare-exchange layers, each step registered.
// When the receiver stalls while a result is shown, the whole pipeline
// holds and in_stall is raised in the same cycle; otherwise a new pixel is
// taken every clock. Reset clears the counters, the pipeline valid bits and
// sets the width to 640; the line store holds no valid data until rows of
// the current image have been written into it.
`default_nettype none

module median_filter_window_top
    import mfw_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,

    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [PIX_W-1:0] pixel,
    input  wire logic             frame_start,

    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [PIX_W-1:0]      median_value,
    output logic                  window_full,
    output logic                  row_end,

    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [IMG_W-1:0] image_width
);

    // Front end: column and row counters and the clamped last-column index.
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] lastcol_reg;
    logic [COL_W-1:0] lastcol_next;

    logic             adv;
    logic             accept;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;
    tag_t             tag_cur;

    // Stage one: pixel waiting for its line store read.
    logic              s1_valid_reg;
    pix_t              s1_pix_reg;
    logic [COL_W-1:0]  s1_col_reg;
    tag_t              s1_tag_reg;
    logic [LINE_W-1:0] rd_reg;
    logic              fwd_reg;
    logic [LINE_W-1:0] fwd_data_reg;

    logic [LINE_W-1:0] line_mem [MAX_WIDTH];
    logic [LINE_W-1:0] line_cur;
    logic [LINE_W-1:0] wr_data;
    logic              wr_en;
    pix_t              column [KSIZE];

    // Stage two: the window itself, which is the payload of this stage.
    win_t window_reg;
    win_t window_next;
    logic s2_valid_reg;
    tag_t s2_tag_reg;

    logic med_valid;
    tag_t med_tag;
    pix_t med_val;

    // The pipeline moves as one unit unless a shown result is held back.
    assign adv       = !(out_valid && out_stall);
    assign in_stall  = !adv;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Clamp the programmed width to 1..MAX_WIDTH and keep width minus one.
    always_comb
    begin
        logic [CMP_W-1:0] w_ext;
        w_ext = CMP_W'(image_width);
        if (w_ext == '0)
        begin
            lastcol_next = '0;
        end
        else if (w_ext > CMP_W'(MAX_WIDTH))
        begin
            lastcol_next = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            lastcol_next = COL_W'(w_ext - CMP_W'(1));
        end
    end

    // A frame start clears the counts before the pixel uses them.
    assign col_cur = frame_start ? '0 : col_reg;
    assign row_cur = frame_start ? '0 : row_reg;

    assign tag_cur.last = (col_cur >= lastcol_reg);
    assign tag_cur.full = (row_cur == ROW_W'(KSIZE - 1)) &&
                          (col_cur >= COL_W'(KSIZE - 1));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (tag_cur.last)
            begin
                col_next = '0;
                row_next = (row_cur == ROW_W'(KSIZE - 1)) ? row_cur
                                                           : row_cur + ROW_W'(1);
            end
            else
            begin
                col_next = col_cur + COL_W'(1);
                row_next = row_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            lastcol_reg <= COL_W'(WIDTH_RESET - 1);
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_valid && cfg_ready)
            begin
                lastcol_reg <= lastcol_next;
            end
        end
    end

    // Line store: one word holds the KSIZE-1 earlier rows at one column.
    // The read is taken at the accepting edge, the write one stage later.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_reg <= line_mem[col_cur];
        end
        if (wr_en)
        begin
            line_mem[s1_col_reg] <= wr_data;
        end
    end

    // When the word read at this edge is being rewritten at the same edge
    // (narrow images or a frame restart), keep the new data for forwarding.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pix_reg   <= pixel;
            s1_col_reg   <= col_cur;
            s1_tag_reg   <= tag_cur;
            fwd_reg      <= s1_valid_reg && (s1_col_reg == col_cur);
            fwd_data_reg <= wr_data;
        end
    end

    assign line_cur = fwd_reg ? fwd_data_reg : rd_reg;

    // New column: oldest row on top, the incoming pixel at the bottom.
    always_comb
    begin
        for (int r = 0; r < LINES; r++)
        begin
            column[r] = line_cur[r*PIX_W +: PIX_W];
        end
        column[KSIZE-1] = s1_pix_reg;
    end

    // Each stored row moves up by one at this column.
    always_comb
    begin
        for (int r = 0; r < LINES; r++)
        begin
            wr_data[r*PIX_W +: PIX_W] = column[r+1];
        end
    end

    assign wr_en = adv && s1_valid_reg;

    // Shift the window left by one column and insert the new one.
    always_comb
    begin
        for (int r = 0; r < KSIZE; r++)
        begin
            for (int c = 0; c < KSIZE - 1; c++)
            begin
                window_next[r*KSIZE + c] = window_reg[r*KSIZE + c + 1];
            end
            window_next[r*KSIZE + KSIZE - 1] = column[r];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            window_reg <= window_next;
            s2_tag_reg <= s1_tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    mfw_median u_median (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s2_valid_reg),
        .in_tag    (s2_tag_reg),
        .in_win    (window_reg),
        .out_valid (med_valid),
        .out_tag   (med_tag),
        .out_med   (med_val)
    );

    // The last sort layer is the output register.
    assign out_valid    = med_valid;
    assign window_full  = med_tag.full;
    assign row_end      = med_tag.last;
    assign median_value = med_tag.full ? med_val : '0;

endmodule

`default_nettype wire

[hdl/mfw_checker.sv]
// Port-level checks for the median filter top level, with its bind.
`default_nettype none

module mfw_checker
    import mfw_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_stall,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire logic [PIX_W-1:0] median_value,
    input wire logic             window_full,
    input wire logic             row_end
);

    // A held result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // A held result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(median_value) && $stable(window_full)
                                   && $stable(row_end))
        else $error("result word changed while stalled");

    // An incomplete window reports zero.
    a_zero_border: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !window_full |-> median_value == '0)
        else $error("nonzero median on an incomplete window");

    // The input side only waits when a shown result is held back.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

    // A held result always backs up the input.
    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input taken while the pipeline is frozen");

endmodule

bind median_filter_window_top mfw_checker u_mfw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .median_value (median_value),
    .window_full  (window_full),
    .row_end      (row_end)
);

`default_nettype wire
